>>> hw/rtl/hslp_pkg.sv
`timescale 1ns / 1ps

package hslp_pkg;

    // Fraction bits of saturation and lightness.
    localparam int FRAC_BITS = 16;

    // Width of S and L values, which go from zero up to one.
    localparam int FW  = FRAC_BITS + 1;
    // Quotient and dividend widths of the pipelined divider.
    localparam int DQW = FRAC_BITS + 3;
    localparam int DNW = DQW + 8;
    // Signed hue after the offset, in 1/64 degree.
    localparam int HW  = 17;
    // Signed m1, unsigned m2 - m1, and the sixty-degree ramp position.
    localparam int MW  = FRAC_BITS + 3;
    localparam int DW  = FRAC_BITS + 2;
    localparam int TW  = 12;
    // Product widths.
    localparam int LPW = 2 * FW;
    localparam int PCW = DW + TW;

    // Reciprocals for the divisions by constants, with their shifts.
    // Lightness: by 255, exact for dividends below 2**24.
    localparam int          RCP_SH_L = 32;
    localparam logic [24:0] RCP255   = 25'd16843010;
    // Percent scaling: by 25 after a shift by two, exact below 2**23.
    localparam int          RCP_SH_P = 28;
    localparam logic [23:0] RCP25    = 24'd10737419;
    // Ramp: by 15 after a shift by eight, exact below 2**20.
    localparam int          RCP_SH_C = 24;
    localparam logic [20:0] RCP15    = 21'd1118482;
    // Reciprocal product widths.
    localparam int LRW = DNW + 25;
    localparam int PRW = DNW + 24;
    localparam int CRW = PCW + 21;

    localparam logic [FW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FW-1:0] HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

    localparam int TURN  = 23040;
    localparam int SIXTY = 3840;

    // Queue between the front end and the back end.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HUE = 2'd0;
    localparam logic [1:0] CFG_SAT = 2'd1;
    localparam logic [1:0] CFG_LUM = 2'd2;

    typedef enum logic [1:0] {
        MAJ_RED,
        MAJ_GREEN,
        MAJ_BLUE
    } t_major;

    // One classified pixel, ready for the dividers.
    typedef struct packed {
        logic           id;
        logic [31:0]    pix;
        logic           eoi;
        logic [DNW-1:0] s_num;
        logic [7:0]     s_den;
        logic [DNW-1:0] h_num;
        logic [7:0]     h_den;
        logic [DNW-1:0] l_num;
        logic           hneg;
        logic [14:0]    hbase;
    } t_job;

    typedef struct packed {
        logic        id;
        logic [31:0] pix;
        logic        eoi;
        logic        hneg;
        logic [14:0] hbase;
    } t_sb_a;

    typedef struct packed {
        logic                 id;
        logic [31:0]          pix;
        logic                 eoi;
        logic signed [HW-1:0] hue;
    } t_sb_b;

    typedef struct packed {
        logic                 id;
        logic [31:0]          pix;
        logic                 eoi;
        logic                 szero;
        logic [FW-1:0]        lum;
        logic signed [MW-1:0] m1;
    } t_sb_c;

    // Fraction to channel byte: v * 255 >> FRAC_BITS, clamped to 0..255.
    function automatic logic [7:0] chan_from_frac(input logic signed [MW-1:0] v);
        logic signed [MW+8:0] p;
        logic signed [MW+8:0] c;
        p = $signed({v[MW-1], v, 8'b0}) - $signed({{9{v[MW-1]}}, v});
        c = p >>> FRAC_BITS;
        if (v < 0) begin
            chan_from_frac = 8'd0;
        end else if (c > 255) begin
            chan_from_frac = 8'd255;
        end else begin
            chan_from_frac = c[7:0];
        end
    endfunction

endpackage

>>> hw/rtl/hslp_div.sv
`timescale 1ns / 1ps

module hslp_div (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [hslp_pkg::DNW-1:0] i_num,
    input  logic [7:0]               i_den,
    output logic [hslp_pkg::DQW-1:0] o_quo
);
    import hslp_pkg::*;

    // One quotient bit per stage, most significant bit first.
    logic [DNW-1:0] r_rem [DQW];
    logic [7:0]     r_den [DQW];
    logic [DQW-1:0] r_quo [DQW];
    logic [DNW-1:0] n_rem [DQW];
    logic [DQW-1:0] n_quo [DQW];
    logic [DNW-1:0] a_rem [DQW];
    logic [7:0]     a_den [DQW];
    logic [DQW-1:0] a_quo [DQW];

    // Inputs of every stage.
    always_comb begin
        a_rem[0] = i_num;
        a_den[0] = i_den;
        a_quo[0] = '0;
        for (int k = 1; k < DQW; k++) begin
            a_rem[k] = r_rem[k-1];
            a_den[k] = r_den[k-1];
            a_quo[k] = r_quo[k-1];
        end
    end

    // Compare and subtract the shifted divisor.
    always_comb begin
        logic [DNW-1:0] dsh;
        for (int k = 0; k < DQW; k++) begin
            dsh = DNW'(a_den[k]) << (DQW - 1 - k);
            if (a_rem[k] >= dsh) begin
                n_rem[k] = a_rem[k] - dsh;
                n_quo[k] = a_quo[k] | (DQW'(1) << (DQW - 1 - k));
            end else begin
                n_rem[k] = a_rem[k];
                n_quo[k] = a_quo[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DQW; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= a_den[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[DQW-1];

endmodule

>>> hw/rtl/hslp_front.sv
`timescale 1ns / 1ps

module hslp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [31:0]       i_pix,
    input  logic              i_eoi,
    input  logic signed [9:0] i_hue_off,
    input  logic [8:0]        i_sat,
    input  logic [8:0]        i_lum,
    output logic              o_job_valid,
    output hslp_pkg::t_job    o_job,
    input  logic              i_job_ready
);
    import hslp_pkg::*;

    logic        r_valid;
    t_job        r_job;
    t_job        n_job;
    logic [7:0]  b, g, r;
    logic [7:0]  mn, mx, d, mag;
    logic [8:0]  sum, rsum, hd;
    t_major      maj;
    logic        gray;

    assign b = i_pix[7:0];
    assign g = i_pix[15:8];
    assign r = i_pix[23:16];

    assign o_ready = !r_valid || i_job_ready;

    // Dominant channel, then numerators and divisors for S, H and L.
    always_comb begin
        if (r < g) begin
            mn = r; mx = g; maj = MAJ_GREEN;
        end else begin
            mn = g; mx = r; maj = MAJ_RED;
        end
        if (b < mn) begin
            mn = b;
        end else if (b > mx) begin
            mx = b; maj = MAJ_BLUE;
        end
        d    = mx - mn;
        sum  = {1'b0, mn} + {1'b0, mx};
        rsum = 9'd510 - sum;
        gray = (d == 8'd0);

        n_job.hbase = 15'd23040;
        unique case (maj)
            MAJ_RED: begin
                hd = {1'b0, g} - {1'b0, b};
                n_job.hbase = 15'd23040;
            end
            MAJ_GREEN: begin
                hd = {1'b0, b} - {1'b0, r};
                n_job.hbase = 15'd7680;
            end
            MAJ_BLUE: begin
                hd = {1'b0, r} - {1'b0, g};
                n_job.hbase = 15'd15360;
            end
            default: begin
                hd = {1'b0, g} - {1'b0, b};
            end
        endcase
        n_job.hneg = hd[8];
        mag = hd[8] ? 8'(-hd) : hd[7:0];

        n_job.id = (i_hue_off == 10'sd0) && (i_sat == 9'd100) && (i_lum == 9'd100);
        n_job.pix = i_pix;
        n_job.eoi = i_eoi;
        n_job.s_num = DNW'(d) << FRAC_BITS;
        n_job.s_den = (sum <= 9'd255) ? sum[7:0] : rsum[7:0];
        n_job.h_num = (DNW'(mag) << 12) - (DNW'(mag) << 8);
        n_job.h_den = d;
        n_job.l_num = DNW'(sum) << (FRAC_BITS - 1);
        // A gray pixel has no hue and no saturation.
        if (gray) begin
            n_job.hbase = 15'd0;
            n_job.s_den = 8'd1;
            n_job.h_den = 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job       = r_job;

endmodule

>>> hw/rtl/hslp_queue.sv
`timescale 1ns / 1ps

module hslp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  hslp_pkg::t_job i_push_job,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output hslp_pkg::t_job o_pop_job
);
    import hslp_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           push, pop;

    assign o_pop_valid  = (r_cnt != '0);
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_push_ready = (r_cnt != (QAW+1)'(QDEPTH)) || pop;
    assign push         = i_push_valid && o_push_ready;
    assign o_pop_job    = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

endmodule

>>> hw/rtl/hslp_back.sv
`timescale 1ns / 1ps

module hslp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  hslp_pkg::t_job    i_job,
    output logic              o_job_ready,
    input  logic signed [9:0] i_hue_off,
    input  logic [8:0]        i_sat,
    input  logic [8:0]        i_lum,
    output logic              o_valid,
    output logic [31:0]       o_pix,
    output logic              o_eoi,
    input  logic              i_ready
);
    import hslp_pkg::*;

    logic en;

    // Wrap a hue into one turn and give its position on the ramp.
    function automatic logic [TW-1:0] ramp_pos(input logic signed [HW:0] x);
        logic signed [HW+1:0] y;
        logic signed [HW+1:0] w;
        y = (HW+2)'(x);
        if (y < -TURN) begin
            w = y + (HW+2)'(2 * TURN);
        end else if (y < 0) begin
            w = y + (HW+2)'(TURN);
        end else if (y < TURN) begin
            w = y;
        end else if (y < 2 * TURN) begin
            w = y - (HW+2)'(TURN);
        end else begin
            w = y - (HW+2)'(2 * TURN);
        end
        if (w < SIXTY) begin
            ramp_pos = w[TW-1:0];
        end else if (w < 3 * SIXTY) begin
            ramp_pos = TW'(SIXTY);
        end else if (w < 4 * SIXTY) begin
            ramp_pos = TW'((HW+2)'(4 * SIXTY) - w);
        end else begin
            ramp_pos = '0;
        end
    endfunction

    // The whole pipeline advances unless a result waits at the output.
    logic r_ov;
    assign en          = !r_ov || i_ready;
    assign o_job_ready = en;

    // Divide stage: S and H of the pixel; L by a reciprocal of 255, delayed alongside.
    logic [DQW-1:0] qa_s, qa_h;
    logic [LRW-1:0] lprod;
    logic [FW-1:0]  lq;
    logic           r_va [DQW];
    t_sb_a          r_sa [DQW];
    logic [FW-1:0]  r_la [DQW];

    hslp_div u_div_s (.i_clk, .i_en(en), .i_num(i_job.s_num), .i_den(i_job.s_den),
                      .o_quo(qa_s));
    hslp_div u_div_h (.i_clk, .i_en(en), .i_num(i_job.h_num), .i_den(i_job.h_den),
                      .o_quo(qa_h));

    assign lprod = LRW'(i_job.l_num) * LRW'(RCP255);
    assign lq    = FW'(lprod >> RCP_SH_L);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa[0] <= '{id: i_job.id, pix: i_job.pix, eoi: i_job.eoi,
                         hneg: i_job.hneg, hbase: i_job.hbase};
            r_la[0] <= lq;
            for (int k = 1; k < DQW; k++) begin
                r_sa[k] <= r_sa[k-1];
                r_la[k] <= r_la[k-1];
            end
        end
    end

    // Hue with offset; S and L times their percentages.
    logic signed [HW-1:0] h0, h1, hue;
    logic                 r_v1;
    t_sb_b                r_x1;
    logic [DNW-1:0]       r_psat, r_plum;

    always_comb begin
        if (r_sa[DQW-1].hneg) begin
            h0 = $signed({2'b0, r_sa[DQW-1].hbase}) - $signed({5'b0, qa_h[TW-1:0]});
        end else begin
            h0 = $signed({2'b0, r_sa[DQW-1].hbase}) + $signed({5'b0, qa_h[TW-1:0]});
        end
        h1  = (h0 >= TURN) ? h0 - HW'(TURN) : h0;
        hue = h1 + $signed({i_hue_off[9], i_hue_off, 6'b0});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1   <= '{id: r_sa[DQW-1].id, pix: r_sa[DQW-1].pix,
                        eoi: r_sa[DQW-1].eoi, hue: hue};
            r_psat <= DNW'(qa_s[FW-1:0]) * DNW'(i_sat);
            r_plum <= DNW'(r_la[DQW-1]) * DNW'(i_lum);
        end
    end

    // Divide by a hundred: a shift by two bits and a reciprocal of 25.
    logic [PRW-1:0] pprod_s, pprod_l;
    logic [DQW-1:0] r_qs, r_ql;
    logic           r_vb;
    t_sb_b          r_xb;

    assign pprod_s = PRW'(r_psat >> 2) * PRW'(RCP25);
    assign pprod_l = PRW'(r_plum >> 2) * PRW'(RCP25);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xb <= r_x1;
            r_qs <= DQW'(pprod_s >> RCP_SH_P);
            r_ql <= DQW'(pprod_l >> RCP_SH_P);
        end
    end

    // Clamp S and L to one and form L * S.
    logic [FW-1:0]  sc, lc, r_s2, r_l2;
    logic [LPW-1:0] r_lsp;
    t_sb_b          r_x2;
    logic           r_v2;

    assign sc = (r_qs > DQW'(ONE)) ? ONE : r_qs[FW-1:0];
    assign lc = (r_ql > DQW'(ONE)) ? ONE : r_ql[FW-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x2  <= r_xb;
            r_s2  <= sc;
            r_l2  <= lc;
            r_lsp <= LPW'(sc) * LPW'(lc);
        end
    end

    // m1, m2 - m1 and the ramp position of each channel.
    logic [FW-1:0]        ls;
    logic [DW-1:0]        m2;
    logic signed [MW-1:0] m1;
    logic [DW-1:0]        diff;
    logic [TW-1:0]        tpos [3];
    logic [TW-1:0]        r_t [3];
    logic [DW-1:0]        r_diff;
    t_sb_c                r_x3;
    logic                 r_v3;

    always_comb begin
        ls = r_lsp[FRAC_BITS +: FW];
        if (r_l2 <= HALF) begin
            m2 = DW'(r_l2) + DW'(ls);
        end else begin
            m2 = DW'(r_l2) + DW'(r_s2) - DW'(ls);
        end
        m1   = $signed(MW'({r_l2, 1'b0})) - $signed(MW'(m2));
        diff = DW'(m2 - DW'(r_l2)) << 1;
        // Blue lags green by a third of a turn, red leads it.
        tpos[0] = ramp_pos($signed({r_x2.hue[HW-1], r_x2.hue}) - (HW+1)'(2 * SIXTY));
        tpos[1] = ramp_pos($signed({r_x2.hue[HW-1], r_x2.hue}));
        tpos[2] = ramp_pos($signed({r_x2.hue[HW-1], r_x2.hue}) + (HW+1)'(2 * SIXTY));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x3   <= '{id: r_x2.id, pix: r_x2.pix, eoi: r_x2.eoi,
                        szero: (r_s2 == '0), lum: r_l2, m1: m1};
            r_diff <= diff;
            for (int i = 0; i < 3; i++) begin
                r_t[i] <= tpos[i];
            end
        end
    end

    // Ramp products.
    logic [PCW-1:0] r_pc [3];
    t_sb_c          r_x4;
    logic           r_v4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x4 <= r_x3;
            for (int i = 0; i < 3; i++) begin
                r_pc[i] <= PCW'(r_diff) * PCW'(r_t[i]);
            end
        end
    end

    // Divide by sixty degrees: a shift by eight bits and a reciprocal of 15.
    logic [CRW-1:0] cprod [3];
    logic [DQW-1:0] r_qc [3];
    logic           r_vc;
    t_sb_c          r_xc;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cprod[i] = CRW'(r_pc[i] >> 8) * CRW'(RCP15);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xc <= r_x4;
            for (int i = 0; i < 3; i++) begin
                r_qc[i] <= DQW'(cprod[i] >> RCP_SH_C);
            end
        end
    end

    // Channel bytes and the output register.
    t_sb_c       xo;
    logic [7:0]  chn [3];
    logic [31:0] r_opix;
    logic        r_oeoi;

    assign xo = r_xc;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (xo.szero) begin
                chn[i] = chan_from_frac($signed(MW'(xo.lum)));
            end else begin
                chn[i] = chan_from_frac(xo.m1 + $signed(MW'(r_qc[i])));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oeoi <= xo.eoi;
            if (xo.id) begin
                r_opix <= xo.pix;
            end else begin
                r_opix <= {xo.pix[31:24], chn[2], chn[1], chn[0]};
            end
        end
    end

    // Valid bits through every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DQW; k++) begin
                r_va[k] <= 1'b0;
            end
            r_v1 <= 1'b0;
            r_vb <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vc <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_va[0] <= i_job_valid;
            for (int k = 1; k < DQW; k++) begin
                r_va[k] <= r_va[k-1];
            end
            r_v1 <= r_va[DQW-1];
            r_vb <= r_v1;
            r_v2 <= r_vb;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_vc <= r_v4;
            r_ov <= r_vc;
        end
    end

    assign o_valid = r_ov;
    assign o_pix   = r_opix;
    assign o_eoi   = r_oeoi;

endmodule

>>> hw/rtl/hsl_adjust_pixel_unit.sv
`timescale 1ns / 1ps

// Hue, saturation and lightness adjustment of a BGRA pixel stream.
// Pixels enter on the s_axis channel (tdata holds blue, green, red, alpha
// from the low byte up; tlast marks the last pixel of an image) and leave
// on m_axis in the same layout, with alpha and tlast copied through.
// Settings are written on the cfg channel: index 0 is the hue offset in
// degrees, 1 the saturation percent and 2 the lightness percent. Write them
// only while no pixel is in flight; o_cfg_ready is always high.
// One pixel is accepted per cycle for as long as the output is taken.
// Saturation and hue go through bit-per-stage divider pipelines. A
// four-entry queue sits between the classifying front end and the
// arithmetic back end. Reset restores offset 0 and both percents to 100
// and empties the pipeline. When a result waits at the output and
// m_axis_tready is low, the back end holds every stage, the queue fills,
// and s_axis_tready drops once the queue and front register are full.
module hsl_adjust_pixel_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // blue_in, green_in, red_in, alpha_in
    input  logic        s_axis_tlast,   // end_of_image
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // blue_out, green_out, red_out, alpha_out
    output logic        m_axis_tlast,   // end_of_image_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    import hslp_pkg::*;

    logic signed [9:0] r_hue_off;
    logic [8:0]        r_sat, r_lum;
    logic              fq_valid, fq_ready, qb_valid, qb_ready;
    t_job              fq_job, qb_job;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_off <= 10'sd0;
            r_sat     <= 9'd100;
            r_lum     <= 9'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HUE: r_hue_off <= $signed(i_cfg_data);
                CFG_SAT: r_sat     <= i_cfg_data[8:0];
                CFG_LUM: r_lum     <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    hslp_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_pix(s_axis_tdata), .i_eoi(s_axis_tlast),
        .i_hue_off(r_hue_off), .i_sat(r_sat), .i_lum(r_lum),
        .o_job_valid(fq_valid), .o_job(fq_job), .i_job_ready(fq_ready)
    );

    hslp_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push_valid(fq_valid), .o_push_ready(fq_ready), .i_push_job(fq_job),
        .o_pop_valid(qb_valid), .i_pop_ready(qb_ready), .o_pop_job(qb_job)
    );

    hslp_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(qb_valid), .i_job(qb_job), .o_job_ready(qb_ready),
        .i_hue_off(r_hue_off), .i_sat(r_sat), .i_lum(r_lum),
        .o_valid(m_axis_tvalid), .o_pix(m_axis_tdata), .o_eoi(m_axis_tlast),
        .i_ready(m_axis_tready)
    );

endmodule

>>> hw/rtl/hslp_checker.sv
`timescale 1ns / 1ps

module hslp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        o_cfg_ready
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A taken output keeps the input open.
    a_ready_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is taken");

    // A stalled result stays until taken.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Configuration writes are never refused.
    a_cfg_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind hsl_adjust_pixel_unit hslp_checker u_hslp_checker (.*);

>>> sim/tb_hsl_adjust_pixel_unit.sv
`timescale 1ns / 1ps

module tb_hsl_adjust_pixel_unit;
    import hslp_pkg::*;

    localparam int LATENCY   = 27;
    localparam int WDOG_MAX  = 4000;
    localparam int RAND_ITEMS = 1134;
    localparam int CALM_ITEMS = 200;
    localparam longint K_ONE   = 64'sd1 << FRAC_BITS;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       eoi;
    } t_pixel;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [9:0]  i_cfg_data;

    hsl_adjust_pixel_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Adjustment settings as the block should hold them.
    longint hue_ofs;
    longint sat_pct;
    longint lum_pct;

    t_pixel pending_px[$];
    t_pixel adjusted_px[$];

    int  mismatches;
    int  idle_cycles;
    bit  calm;
    bit  hold_src;
    bit  src_taken;
    int  src_gap;
    int  snk_gap;

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Fraction to byte with clamping.
    function automatic logic [7:0] frac_to_byte(input longint v);
        longint c;
        if (v < 0) v = 0;
        c = (v * 255) >>> FRAC_BITS;
        if (c > 255) c = 255;
        return c[7:0];
    endfunction

    function automatic logic [7:0] hue_channel(input longint m1, input longint m2,
                                               input longint h);
        longint v;
        h = h % TURN;
        if (h < 0) h += TURN;
        if (h < SIXTY) v = m1 + (m2 - m1) * h / SIXTY;
        else if (h < 3 * SIXTY) v = m2;
        else if (h < 4 * SIXTY) v = m1 + (m2 - m1) * (4 * SIXTY - h) / SIXTY;
        else v = m1;
        return frac_to_byte(v);
    endfunction

    // Expected adjusted pixel for the current settings.
    function automatic t_pixel adjust_pixel(input t_pixel p);
        t_pixel q;
        longint b, g, r, mn, mx, h, s, l, d, sum, ls, m1, m2;
        t_major major;
        q = p;
        b = p.blue;
        g = p.green;
        r = p.red;
        if (hue_ofs == 0 && sat_pct == 100 && lum_pct == 100) return q;
        if (r < g) begin
            mn = r; mx = g; major = MAJ_GREEN;
        end else begin
            mn = g; mx = r; major = MAJ_RED;
        end
        if (b < mn) mn = b;
        else if (b > mx) begin
            mx = b; major = MAJ_BLUE;
        end
        if (mn == mx) begin
            l = mn * K_ONE / 255;
            s = 0;
            h = 0;
        end else begin
            d = mx - mn;
            sum = mn + mx;
            l = sum * K_ONE / 510;
            if (sum <= 255) s = d * K_ONE / sum;
            else s = d * K_ONE / (510 - sum);
            case (major)
                MAJ_RED:   h = (g - b) * 3840 / d + 6 * SIXTY;
                MAJ_GREEN: h = (b - r) * 3840 / d + 2 * SIXTY;
                default:   h = (r - g) * 3840 / d + 4 * SIXTY;
            endcase
            if (h >= TURN) h -= TURN;
        end
        h += hue_ofs * 64;
        s = s * sat_pct / 100;
        l = l * lum_pct / 100;
        if (s > K_ONE) s = K_ONE;
        if (l > K_ONE) l = K_ONE;
        if (s == 0) begin
            q.blue = frac_to_byte(l);
            q.green = q.blue;
            q.red = q.blue;
        end else begin
            ls = (l * s) >>> FRAC_BITS;
            m2 = (l <= K_ONE / 2) ? l + ls : l + s - ls;
            m1 = 2 * l - m2;
            q.red = hue_channel(m1, m2, h + 2 * SIXTY);
            q.green = hue_channel(m1, m2, h);
            q.blue = hue_channel(m1, m2, h - 2 * SIXTY);
        end
        return q;
    endfunction

    // Input handshakes, sampled at the rising edge.
    always @(posedge i_clk) begin
        src_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    // Source driver: presents queued pixels, with random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (src_taken) begin
                adjusted_px.push_back(adjust_pixel(pending_px.pop_front()));
            end
            if (s_axis_tvalid && !src_taken) begin
                // Hold the beat until it is taken.
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (!calm && !hold_src && $urandom_range(0, 9) == 0) begin
                src_gap <= $urandom_range(0, 2);
                s_axis_tvalid <= 1'b0;
            end else if (pending_px.size() > 0 && !hold_src) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {pending_px[0].alpha, pending_px[0].red,
                                 pending_px[0].green, pending_px[0].blue};
                s_axis_tlast <= pending_px[0].eoi;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            snk_gap <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: compares each output beat with the oldest expected pixel.
    always @(posedge i_clk) begin
        t_pixel e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (adjusted_px.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: data %h last %b", m_axis_tdata, m_axis_tlast);
            end else begin
                e = adjusted_px.pop_front();
                if (m_axis_tdata !== {e.alpha, e.red, e.green, e.blue}
                        || m_axis_tlast !== e.eoi) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b got %h/%b",
                                 {e.alpha, e.red, e.green, e.blue}, e.eoi,
                                 m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("tb_hsl_adjust_pixel_unit NOT OK");
                $finish;
            end
        end
    end

    task automatic add_pixel(input int b, input int g, input int r, input int a, input bit t);
        t_pixel p;
        p.blue = 8'(b);
        p.green = 8'(g);
        p.red = 8'(r);
        p.alpha = 8'(a);
        p.eoi = t;
        pending_px.push_back(p);
    endtask

    task automatic add_random_pixel();
        int mode;
        int v;
        mode = $urandom_range(0, 5);
        v = $urandom_range(0, 255);
        if (mode == 0)
            add_pixel(v, v, v, $urandom_range(0, 255), $urandom_range(0, 15) == 0);
        else if (mode == 1)
            add_pixel(v, v, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 15) == 0);
        else
            add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 15) == 0);
    endtask

    // Waits until every queued pixel has come back, then lets the pipe drain.
    task automatic drain();
        while (pending_px.size() > 0 || adjusted_px.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[9:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_HUE) hue_ofs = value[9] ? longint'(value[9:0]) - 1024
                                             : longint'(value[9:0]);
        else if (idx == CFG_SAT) sat_pct = value[8:0];
        else lum_pct = value[8:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_all(input int hue, input int sat, input int lum);
        drain();
        write_reg(CFG_HUE, hue);
        write_reg(CFG_SAT, sat);
        write_reg(CFG_LUM, lum);
    endtask

    initial begin
        int k;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_HUE;
        i_cfg_data = '0;
        hue_ofs = 0;
        sat_pct = 100;
        lum_pct = 100;
        mismatches = 0;
        idle_cycles = 0;
        calm = 1'b0;
        hold_src = 1'b0;
        src_gap = 0;
        snk_gap = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Identity settings pass the pixel through.
        add_pixel(0, 0, 0, 0, 0);
        add_pixel(255, 255, 255, 255, 1);
        add_pixel(12, 200, 77, 128, 0);
        drain();

        // Directed pixels under a non-identity setting: each major channel,
        // ties, gray, extremes.
        set_all(30, 150, 80);
        add_pixel(0, 0, 0, 0, 0);
        add_pixel(255, 255, 255, 255, 1);
        add_pixel(0, 0, 255, 170, 0);
        add_pixel(0, 255, 0, 85, 0);
        add_pixel(255, 0, 0, 1, 1);
        add_pixel(255, 255, 0, 254, 0);
        add_pixel(0, 255, 255, 2, 0);
        add_pixel(255, 0, 255, 3, 0);
        add_pixel(128, 128, 128, 4, 0);
        add_pixel(10, 200, 200, 5, 0);
        add_pixel(200, 10, 200, 6, 0);
        add_pixel(200, 200, 10, 7, 0);
        add_pixel(1, 2, 3, 8, 1);

        // Once every result is back, hold the source with a pixel queued.
        while (adjusted_px.size() > 0 || pending_px.size() > 0) @(posedge i_clk);
        hold_src = 1'b1;
        add_pixel(100, 50, 250, 9, 0);
        repeat (5) @(posedge i_clk);
        hold_src = 1'b0;

        // Settings phases with random pixels: fixed extremes first, then random settings.
        for (k = 0; k < 9; k++) begin
            case (k)
                0: set_all(-360, 0, 0);
                1: set_all(360, 400, 400);
                2: set_all(511, 511, 511);
                3: set_all(-512, 100, 100);
                4: set_all(0, 100, 99);
                5: set_all(0, 511, 100);
                default: set_all($urandom_range(0, 1023), $urandom_range(0, 400),
                                 $urandom_range(0, 400));
            endcase
            repeat (RAND_ITEMS / 9) add_random_pixel();
        end

        // Last part without idling.
        drain();
        calm = 1'b1;
        set_all($urandom_range(0, 720) - 360, $urandom_range(0, 400), $urandom_range(0, 400));
        repeat (CALM_ITEMS) add_random_pixel();
        drain();

        if (mismatches == 0) begin
            $display("tb_hsl_adjust_pixel_unit OK");
        end else begin
            $display("tb_hsl_adjust_pixel_unit NOT OK");
        end
        $finish;
    end
endmodule

>>> hsl_adjust_pixel_unit.f
hw/rtl/hslp_pkg.sv
hw/rtl/hslp_div.sv
hw/rtl/hslp_front.sv
hw/rtl/hslp_queue.sv
hw/rtl/hslp_back.sv
hw/rtl/hsl_adjust_pixel_unit.sv
hw/rtl/hslp_checker.sv
sim/tb_hsl_adjust_pixel_unit.sv
